/* rtl/rmq_pkg.sv */
// Shared constants and types for the rotation matrix to quaternion core.
// Depends on nothing; every module of the core imports it.
`default_nettype none
package rmq_pkg;

	// Default number of fraction bits of the fixed-point format.
	localparam int RMQ_FRAC_BITS_DEF = 14;
	// Width of one matrix element and one quaternion component.
	localparam int RMQ_EW = 16;
	// Width of an off-diagonal sum or difference, and of a quotient magnitude.
	localparam int RMQ_SW = 17;
	localparam int RMQ_QW = 17;
	// Number of quotient lanes, one for each component that is not the chosen one.
	localparam int RMQ_LANES = 3;

	// Chosen component.
	typedef enum logic [1:0] {
		SEL_X = 2'd0,
		SEL_Y = 2'd1,
		SEL_Z = 2'd2,
		SEL_W = 2'd3
	} rmq_sel_t;

	// Control that travels with each item along the chain.
	typedef struct packed {
		logic     valid;
		rmq_sel_t sel;
	} rmq_ctl_t;

endpackage
`default_nettype wire

/* rtl/rmq_sqrt_cell.sv */
// One cell of the square root chain: settles one root bit per cell.
// Depends on rmq_pkg.
`default_nettype none
module rmq_sqrt_cell import rmq_pkg::*; #(
	parameter int NW = 26,
	parameter int SW = 13,
	parameter int XW = 51
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire rmq_ctl_t      ctl_i,
	input  wire logic [NW-1:0] n_i,
	input  wire logic [SW-1:0] root_i,
	input  wire logic [SW+2:0] rem_i,
	input  wire logic [XW-1:0] x_i,
	output rmq_ctl_t           ctl_o,
	output logic [NW-1:0]      n_o,
	output logic [SW-1:0]      root_o,
	output logic [SW+2:0]      rem_o,
	output logic [XW-1:0]      x_o
);

	logic [SW+2:0] t;
	logic [SW+2:0] trial;
	logic          ge;

	// Bring down the next two radicand bits and try the next root bit.
	always_comb begin
		t     = {rem_i[SW:0], n_i[NW-1 -: 2]};
		trial = {1'b0, root_i, 2'b01};
		ge    = (t >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_o    <= {n_i[NW-3:0], 2'b00};
			root_o <= {root_i[SW-2:0], ge};
			rem_o  <= ge ? (t - trial) : t;
			x_o    <= x_i;
		end
	end

endmodule
`default_nettype wire

/* rtl/rmq_div_cell.sv */
// One cell of the divider chain: settles one quotient bit in each of three lanes.
// Depends on rmq_pkg.
`default_nettype none
module rmq_div_cell import rmq_pkg::*; #(
	parameter int SW = 13
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire rmq_ctl_t                     ctl_i,
	input  wire logic [SW-1:0]                c_i,
	input  wire logic [2*RMQ_LANES-1:0]       flg_i,
	input  wire logic [RMQ_LANES-1:0][SW+2:0] rem_i,
	input  wire logic [RMQ_LANES-1:0][RMQ_QW-1:0] lo_i,
	input  wire logic [RMQ_LANES-1:0][RMQ_QW-1:0] q_i,
	output rmq_ctl_t                          ctl_o,
	output logic [SW-1:0]                     c_o,
	output logic [2*RMQ_LANES-1:0]            flg_o,
	output logic [RMQ_LANES-1:0][SW+2:0]      rem_o,
	output logic [RMQ_LANES-1:0][RMQ_QW-1:0]  lo_o,
	output logic [RMQ_LANES-1:0][RMQ_QW-1:0]  q_o
);

	logic [SW+2:0]                     den;
	logic [RMQ_LANES-1:0][SW+2:0]      t;
	logic [RMQ_LANES-1:0]              ge;

	// Restoring division step against four times the root.
	always_comb begin
		den = {1'b0, c_i, 2'b00};
		for (int i = 0; i < RMQ_LANES; i++) begin
			t[i]  = {rem_i[i][SW+1:0], lo_i[i][RMQ_QW-1]};
			ge[i] = (t[i] >= den);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_o   <= c_i;
			flg_o <= flg_i;
			for (int i = 0; i < RMQ_LANES; i++) begin
				rem_o[i] <= ge[i] ? (t[i] - den) : t[i];
				lo_o[i]  <= {lo_i[i][RMQ_QW-2:0], 1'b0};
				q_o[i]   <= {q_i[i][RMQ_QW-2:0], ge[i]};
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/rotation_matrix_to_quaternion_core.sv */
// Top level: rotation matrix to unit quaternion by Shepperd's method.
// Depends on rmq_pkg, rmq_sqrt_cell and rmq_div_cell.
//
//  Channel | Dir | Handshake         | Payload
//  s_*     | in  | s_tvalid/s_tready | s_tdata: m00..m22, 16 bits each
//  m_*     | out | m_tvalid/m_tready | m_tdata: quat_x, quat_y, quat_z, quat_w
//
// One matrix is taken in every cycle while the chain advances. Stage 1 feeds one
// cell per bit of an SW-bit root (13 at 8 fraction bits, 16 at 14), then stage 2.
// The whole chain advances when the output register is empty or being read;
// while m_tready is low with a result held, every stage holds.
// Reset clears only valid and select bits; no item is lost or repeated in stalls.
`default_nettype none
module rotation_matrix_to_quaternion_core import rmq_pkg::*; #(
	parameter int FRAC_BITS = RMQ_FRAC_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up, 16 bits each
	input  wire logic [143:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// quat_x, quat_y, quat_z, quat_w from bit 0 up, 16 bits each
	output logic [63:0]       m_tdata
);

	localparam int RW  = ((FRAC_BITS > 18) ? FRAC_BITS : 18) + 2;
	localparam int NW0 = RW - 1 + FRAC_BITS - 2;
	localparam int NW  = NW0 + (NW0 % 2);
	localparam int SW  = NW / 2;
	localparam int XW  = RMQ_LANES * RMQ_SW;
	localparam int NDW = RMQ_SW + FRAC_BITS + 1;

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Stage 1: candidate sums, selection, radicand and off-diagonal terms.
	logic signed [RMQ_EW-1:0] m [9];
	logic signed [RW-1:0] d0, d1, d2, d3, dm, rr;
	rmq_sel_t sel_c;
	logic signed [RMQ_SW-1:0] a01, a02, a12, b12, b20, b01;
	logic [RMQ_LANES-1:0][RMQ_SW-1:0] lanes_c;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			m[i] = s_tdata[i*RMQ_EW +: RMQ_EW];
		end
		d0 = RW'(m[0]) - RW'(m[4]) - RW'(m[8]);
		d1 = RW'(m[4]) - RW'(m[0]) - RW'(m[8]);
		d2 = RW'(m[8]) - RW'(m[0]) - RW'(m[4]);
		d3 = RW'(m[0]) + RW'(m[4]) + RW'(m[8]);
		dm = d0;
		sel_c = SEL_X;
		if (d1 > dm) begin
			dm = d1;
			sel_c = SEL_Y;
		end
		if (d2 > dm) begin
			dm = d2;
			sel_c = SEL_Z;
		end
		if (d3 > dm) begin
			dm = d3;
			sel_c = SEL_W;
		end
		rr = dm + (RW'(1) <<< FRAC_BITS);
		if (rr < RW'(1)) begin
			rr = RW'(1);
		end
		a01 = RMQ_SW'(m[3]) + RMQ_SW'(m[1]);
		a02 = RMQ_SW'(m[2]) + RMQ_SW'(m[6]);
		a12 = RMQ_SW'(m[7]) + RMQ_SW'(m[5]);
		b12 = RMQ_SW'(m[7]) - RMQ_SW'(m[5]);
		b20 = RMQ_SW'(m[2]) - RMQ_SW'(m[6]);
		b01 = RMQ_SW'(m[3]) - RMQ_SW'(m[1]);
		case (sel_c)
			SEL_X:   lanes_c = {b12, a02, a01};
			SEL_Y:   lanes_c = {b20, a12, a01};
			SEL_Z:   lanes_c = {b01, a12, a02};
			SEL_W:   lanes_c = {b01, b20, b12};
			default: lanes_c = {b01, b20, b12};
		endcase
	end

	rmq_ctl_t      ctl_s1;
	logic [NW-1:0] n_s1;
	logic [XW-1:0] x_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= s_tvalid;
			ctl_s1.sel   <= sel_c;
		end
	end

	// The radicand, shifted up by FRAC_BITS-2, sits high in the even-width root input.
	always_ff @(posedge clk) begin
		if (en) begin
			n_s1 <= NW'(rr[RW-2:0]) << (FRAC_BITS - 2);
			x_s1 <= lanes_c;
		end
	end

	// Square root chain, one root bit per cell.
	rmq_ctl_t      sq_ctl  [SW+1];
	logic [NW-1:0] sq_n    [SW+1];
	logic [SW-1:0] sq_root [SW+1];
	logic [SW+2:0] sq_rem  [SW+1];
	logic [XW-1:0] sq_x    [SW+1];

	assign sq_ctl[0]  = ctl_s1;
	assign sq_n[0]    = n_s1;
	assign sq_root[0] = '0;
	assign sq_rem[0]  = '0;
	assign sq_x[0]    = x_s1;

	for (genvar g = 0; g < SW; g++) begin : g_sqrt
		rmq_sqrt_cell #(.NW(NW), .SW(SW), .XW(XW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_i  (sq_ctl[g]),
			.n_i    (sq_n[g]),
			.root_i (sq_root[g]),
			.rem_i  (sq_rem[g]),
			.x_i    (sq_x[g]),
			.ctl_o  (sq_ctl[g+1]),
			.n_o    (sq_n[g+1]),
			.root_o (sq_root[g+1]),
			.rem_o  (sq_rem[g+1]),
			.x_o    (sq_x[g+1])
		);
	end

	// Stage 2: numerators for rounding, overflow check and sign of each lane.
	logic [SW-1:0]                         c_r;
	logic [RMQ_LANES-1:0][RMQ_SW-1:0]      sv;
	logic [RMQ_LANES-1:0][RMQ_QW-1:0]      mag;
	logic [RMQ_LANES-1:0][NDW-1:0]         num;
	logic [RMQ_LANES-1:0]                  neg_c, ovf_c;
	logic [RMQ_LANES-1:0][SW+2:0]          rem0_c;
	logic [RMQ_LANES-1:0][RMQ_QW-1:0]      lo0_c;
	logic [NDW-1:0]                        den_w;

	always_comb begin
		c_r   = sq_root[SW];
		sv    = sq_x[SW];
		den_w = NDW'({c_r, 2'b00});
		for (int i = 0; i < RMQ_LANES; i++) begin
			neg_c[i]  = sv[i][RMQ_SW-1];
			mag[i]    = neg_c[i] ? (RMQ_QW'(0) - sv[i]) : sv[i];
			num[i]    = (NDW'(mag[i]) << FRAC_BITS) + NDW'({c_r, 1'b0});
			ovf_c[i]  = ((num[i] >> RMQ_QW) >= den_w);
			rem0_c[i] = (SW+3)'(num[i] >> RMQ_QW);
			lo0_c[i]  = num[i][RMQ_QW-1:0];
		end
	end

	rmq_ctl_t                          ctl_s2;
	logic [SW-1:0]                     c_s2;
	logic [2*RMQ_LANES-1:0]            flg_s2;
	logic [RMQ_LANES-1:0][SW+2:0]      rem_s2;
	logic [RMQ_LANES-1:0][RMQ_QW-1:0]  lo_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= sq_ctl[SW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s2   <= c_r;
			flg_s2 <= {ovf_c, neg_c};
			rem_s2 <= rem0_c;
			lo_s2  <= lo0_c;
		end
	end

	// Divider chain, one quotient bit per cell in each lane.
	rmq_ctl_t                          dv_ctl [RMQ_QW+1];
	logic [SW-1:0]                     dv_c   [RMQ_QW+1];
	logic [2*RMQ_LANES-1:0]            dv_flg [RMQ_QW+1];
	logic [RMQ_LANES-1:0][SW+2:0]      dv_rem [RMQ_QW+1];
	logic [RMQ_LANES-1:0][RMQ_QW-1:0]  dv_lo  [RMQ_QW+1];
	logic [RMQ_LANES-1:0][RMQ_QW-1:0]  dv_q   [RMQ_QW+1];

	assign dv_ctl[0] = ctl_s2;
	assign dv_c[0]   = c_s2;
	assign dv_flg[0] = flg_s2;
	assign dv_rem[0] = rem_s2;
	assign dv_lo[0]  = lo_s2;
	assign dv_q[0]   = '0;

	for (genvar g = 0; g < RMQ_QW; g++) begin : g_div
		rmq_div_cell #(.SW(SW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_i  (dv_ctl[g]),
			.c_i    (dv_c[g]),
			.flg_i  (dv_flg[g]),
			.rem_i  (dv_rem[g]),
			.lo_i   (dv_lo[g]),
			.q_i    (dv_q[g]),
			.ctl_o  (dv_ctl[g+1]),
			.c_o    (dv_c[g+1]),
			.flg_o  (dv_flg[g+1]),
			.rem_o  (dv_rem[g+1]),
			.lo_o   (dv_lo[g+1]),
			.q_o    (dv_q[g+1])
		);
	end

	// Output stage: saturate, sign and place the components.
	logic [RMQ_LANES-1:0][RMQ_EW-1:0] lane_out;
	logic [RMQ_EW-1:0]                c_out;
	logic [RMQ_QW-1:0]                qm;
	logic [63:0]                      data_c;
	rmq_sel_t                         sel_o;
	logic                             ovf, ngt;

	always_comb begin
		for (int i = 0; i < RMQ_LANES; i++) begin
			qm  = dv_q[RMQ_QW][i];
			ngt = dv_flg[RMQ_QW][i];
			ovf = dv_flg[RMQ_QW][RMQ_LANES + i];
			if (ngt) begin
				if (ovf || qm > RMQ_QW'(32768)) begin
					lane_out[i] = 16'h8000;
				end else begin
					lane_out[i] = RMQ_EW'(RMQ_QW'(0) - qm);
				end
			end else begin
				if (ovf || qm > RMQ_QW'(32767)) begin
					lane_out[i] = 16'h7fff;
				end else begin
					lane_out[i] = RMQ_EW'(qm);
				end
			end
		end
		if (32'(dv_c[RMQ_QW]) > 32'd32767) begin
			c_out = 16'h7fff;
		end else begin
			c_out = RMQ_EW'(dv_c[RMQ_QW]);
		end
		sel_o = dv_ctl[RMQ_QW].sel;
		// The chosen component takes its slot; the lanes fill the others in order.
		case (sel_o)
			SEL_X:   data_c = {lane_out[2], lane_out[1], lane_out[0], c_out};
			SEL_Y:   data_c = {lane_out[2], lane_out[1], c_out, lane_out[0]};
			SEL_Z:   data_c = {lane_out[2], c_out, lane_out[1], lane_out[0]};
			SEL_W:   data_c = {c_out, lane_out[2], lane_out[1], lane_out[0]};
			default: data_c = {c_out, lane_out[2], lane_out[1], lane_out[0]};
		endcase
	end

	logic        m_tvalid_q;
	logic [63:0] m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= dv_ctl[RMQ_QW].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata_q <= data_c;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire

/* test/tb_rotation_matrix_to_quaternion_core.sv */
// Testbench for the rotation matrix to quaternion core: directed and random matrices.
// Depends on rmq_pkg and rotation_matrix_to_quaternion_core; a scoreboard class predicts results.
`default_nettype none
module tb_rotation_matrix_to_quaternion_core;
	import rmq_pkg::*;

	localparam int FB = RMQ_FRAC_BITS_DEF;
	localparam int LATENCY = 2 + 16 + 1 + 17;

	// Scoreboard: predicts each quaternion and checks results in order.
	class quat_scoreboard;
		logic [63:0] pending_quats[$];
		int errors = 0;

		function automatic longint isqrt(longint n);
			longint res, bitv;
			res = 0;
			bitv = 64'sd1 <<< 62;
			while (bitv > n) bitv = bitv >>> 2;
			while (bitv != 0) begin
				if (n >= res + bitv) begin
					n = n - res - bitv;
					res = (res >>> 1) + bitv;
				end else begin
					res = res >>> 1;
				end
				bitv = bitv >>> 2;
			end
			return res;
		endfunction

		function automatic longint scaled_quot(longint s, longint c);
			longint mag, den, q;
			mag = (s < 0 ? -s : s) <<< FB;
			den = c * 4;
			q = (mag + den / 2) / den;
			return s < 0 ? -q : q;
		endfunction

		function automatic logic [15:0] clip16(longint v);
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			return v[15:0];
		endfunction

		// Notes an accepted matrix and queues the quaternion it must produce.
		function void note_matrix(logic [143:0] mat);
			longint m[9];
			longint d, t, r, c;
			longint q[4];
			rmq_sel_t sel;
			for (int i = 0; i < 9; i++) m[i] = longint'($signed(mat[16*i +: 16]));
			sel = SEL_X;
			d = m[0] - m[4] - m[8];
			t = m[4] - m[0] - m[8];
			if (t > d) begin sel = SEL_Y; d = t; end
			t = m[8] - m[0] - m[4];
			if (t > d) begin sel = SEL_Z; d = t; end
			t = m[0] + m[4] + m[8];
			if (t > d) begin sel = SEL_W; d = t; end
			r = d + (64'sd1 <<< FB);
			if (r < 1) r = 1;
			c = isqrt(r <<< (FB - 2));
			case (sel)
				SEL_X: begin
					q[0] = c; q[1] = scaled_quot(m[3] + m[1], c);
					q[2] = scaled_quot(m[2] + m[6], c); q[3] = scaled_quot(m[7] - m[5], c);
				end
				SEL_Y: begin
					q[0] = scaled_quot(m[3] + m[1], c); q[1] = c;
					q[2] = scaled_quot(m[7] + m[5], c); q[3] = scaled_quot(m[2] - m[6], c);
				end
				SEL_Z: begin
					q[0] = scaled_quot(m[2] + m[6], c); q[1] = scaled_quot(m[7] + m[5], c);
					q[2] = c; q[3] = scaled_quot(m[3] - m[1], c);
				end
				default: begin
					q[0] = scaled_quot(m[7] - m[5], c); q[1] = scaled_quot(m[2] - m[6], c);
					q[2] = scaled_quot(m[3] - m[1], c); q[3] = c;
				end
			endcase
			pending_quats.push_back({clip16(q[3]), clip16(q[2]), clip16(q[1]), clip16(q[0])});
		endfunction

		// Checks one result against the oldest prediction, field by field.
		function void check_quat(logic [63:0] got);
			logic [63:0] exp_q;
			if (pending_quats.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			exp_q = pending_quats.pop_front();
			for (int k = 0; k < 4; k++)
				if (got[16*k +: 16] !== exp_q[16*k +: 16]) begin
					$display("%0t: component %0d expected %h actual %h", $time, k,
						exp_q[16*k +: 16], got[16*k +: 16]);
					errors++;
				end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [143:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [63:0] m_tdata;

	quat_scoreboard sb = new();
	bit quiet_tail = 0;
	bit hold_sink = 0;

	rotation_matrix_to_quaternion_core dut (.*);

	always #4 clk = ~clk;

	// Record accepted transactions and check results at the rising edge.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) sb.note_matrix(s_tdata);
		if (arst_n && m_tvalid && m_tready) sb.check_quat(m_tdata);
	end

	// Receiver: random stall bursts, a long hold-off on request, none at the tail.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				m_tready <= 0;
				repeat (300) @(negedge clk);
				hold_sink = 0;
				m_tready <= 1;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				m_tready <= 0;
				repeat ($urandom_range(1, 13) - 1) @(negedge clk);
			end else begin
				m_tready <= 1;
			end
		end
	end

	function automatic logic [15:0] pick_elem();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'h4000;
			4: return 16'(int'($urandom_range(0, 32768)) - 16384);
			default: return 16'($urandom);
		endcase
	endfunction

	// A rotation-like matrix: a signed permutation with perturbation.
	function automatic logic [143:0] near_rotation();
		logic [143:0] mat;
		int perm[3];
		int p, j;
		int v;
		mat = '0;
		p = $urandom_range(0, 5);
		perm[0] = p / 2; perm[1] = (perm[0] + 1 + p % 2) % 3; perm[2] = 3 - perm[0] - perm[1];
		for (int i = 0; i < 3; i++)
			for (j = 0; j < 3; j++) begin
				v = (perm[i] == j) ? ($urandom_range(0, 1) ? 16384 : -16384) : 0;
				v = v + int'($urandom_range(0, 16384)) - 8192;
				mat[16*(3*i + j) +: 16] = 16'(v);
			end
		return mat;
	endfunction

	// Offers one matrix and waits until it is accepted.
	task automatic send_matrix(logic [143:0] mat);
		s_tdata <= mat;
		s_tvalid <= 1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
	endtask

	task automatic drain_all();
		s_tvalid <= 0;
		while (sb.pending_quats.size() != 0) @(negedge clk);
	endtask

	initial begin
		logic [143:0] mat;
		repeat (10) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed: identity, half-turns, extremes, ties and tiny radicands.
		send_matrix({16'd16384, 48'd0, 16'd16384, 48'd0, 16'd16384});
		send_matrix({-16'sd16384, 48'd0, -16'sd16384, 48'd0, 16'sd16384});
		send_matrix({-16'sd16384, 48'd0, 16'sd16384, 48'd0, -16'sd16384});
		send_matrix({16'sd16384, 48'd0, -16'sd16384, 48'd0, -16'sd16384});
		send_matrix('0);
		send_matrix({9{16'h8000}});
		send_matrix({9{16'h7fff}});
		send_matrix({9{16'hffff}});
		send_matrix({16'h8000, 48'h7fff_8000_7fff, 16'h8000, 48'h7fff_8000_7fff, 16'h8000});
		send_matrix({16'h7fff, 48'h8000_7fff_8000, 16'h7fff, 48'h8000_7fff_8000, 16'h7fff});
		send_matrix({16'h8000, 48'h0, 16'h8000, 48'h0, 16'h8000});
		send_matrix({16'h7fff, 48'h0, 16'h8000, 48'h0, 16'h8000});
		send_matrix({16'h5555, 48'h0, 16'haaaa, 48'h0, 16'h5555});
		send_matrix({16'haaaa, 48'h0, 16'h5555, 48'h0, 16'haaaa});
		drain_all();

		// Random: mostly near-rotations, the rest arbitrary patterns.
		for (int n = 0; n < 1550; n++) begin
			if (n == 500) begin
				hold_sink = 1;
			end
			if (n == 900) begin
				drain_all();
			end
			if (n == 1400) quiet_tail = 1;
			if ($urandom_range(0, 3) != 0) mat = near_rotation();
			else for (int e = 0; e < 9; e++) mat[16*e +: 16] = pick_elem();
			send_matrix(mat);
		end
		drain_all();
		repeat (LATENCY + 10) @(negedge clk);
		if (sb.errors == 0 && sb.pending_quats.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire

/* rotation_matrix_to_quaternion_core.f */
rtl/rmq_pkg.sv
rtl/rmq_sqrt_cell.sv
rtl/rmq_div_cell.sv
rtl/rotation_matrix_to_quaternion_core.sv
test/tb_rotation_matrix_to_quaternion_core.sv
